FILE: rtl/rcps_pkg.sv
// Package for the centroid probe select unit: field widths, defaults, codes.
// No dependencies.
package rcps_pkg;

  localparam int unsigned MaxCentroidsDef = 64;
  localparam int unsigned MaxDimDef       = 128;
  localparam int unsigned ValueBitsDef    = 16;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned IdW     = 24;
  localparam int unsigned ScoreW  = 48;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned ElemW   = 7;
  localparam int unsigned RankW   = 6;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgAddrW-1:0] CfgMetric = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgCount  = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgDim    = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgProbe  = 2'd3;

  localparam logic ActCentroid = 1'b0;
  localparam logic ActQuery    = 1'b1;

endpackage

FILE: rtl/rcps_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module rcps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/restricted_centroid_probe_select_unit.sv
// Top level of the centroid probe select unit.
// Depends on rcps_pkg and rcps_ram.
// Flow: a centroid write or a non-final query element is only stored. The final
// query element triggers scoring of all count*dim elements through one multiply-
// accumulate on the centroid memory port, then each result passes a selection
// scan, a mark state and an emit state, which holds while the output stalls.
// Input stalls from the final query element until its last result is taken.
// Reset clears control and returns configuration to its defaults; memories are undefined until written.
module restricted_centroid_probe_select_unit
  import rcps_pkg::*;
#(
  parameter int unsigned MaxCentroids = MaxCentroidsDef,
  parameter int unsigned MaxDim       = MaxDimDef,
  parameter int unsigned ValueBits    = ValueBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcps_pkg::CfgAddrW-1:0] cfg_index_i,
  input  logic [rcps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [rcps_pkg::SlotW-1:0]    slot_i,
  input  logic [rcps_pkg::ElemW-1:0]    element_index_i,
  input  logic signed [rcps_pkg::ValueW-1:0] value_i,
  input  logic [rcps_pkg::IdW-1:0]      centroid_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rcps_pkg::IdW-1:0]      list_id_o,
  output logic signed [rcps_pkg::ScoreW-1:0] score_o,
  output logic [rcps_pkg::RankW-1:0]    rank_o,
  output logic                          last_o
);
  localparam int unsigned CW = (MaxCentroids > 1) ? $clog2(MaxCentroids) : 1;
  localparam int unsigned DW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned CntW = $clog2(MaxCentroids + 1);
  localparam int unsigned DimW = $clog2(MaxDim + 1);
  localparam int unsigned StoreD = MaxCentroids * MaxDim;
  localparam int unsigned SW = $clog2(StoreD) > 0 ? $clog2(StoreD) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScore = 3'd1;
  localparam logic [2:0] StSel   = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StMark  = 3'd4;

  logic       metric_q;
  logic [6:0] count_q;
  logic [7:0] dim_q;
  logic [6:0] probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= 1'b0;
      count_q  <= 7'd64;
      dim_q    <= 8'd128;
      probe_q  <= 7'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMetric: metric_q <= cfg_data_i[0];
        CfgCount:  count_q  <= cfg_data_i[6:0];
        CfgDim:    dim_q    <= cfg_data_i;
        CfgProbe:  probe_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective counts
  logic [CntW-1:0] cnt_eff;
  logic [DimW-1:0] dim_eff;
  logic [CntW-1:0] n_eff;
  always_comb begin
    if (count_q == 7'd0) cnt_eff = CntW'(1);
    else if (32'(count_q) > MaxCentroids) cnt_eff = CntW'(MaxCentroids);
    else cnt_eff = CntW'(count_q);
    if (dim_q == 8'd0) dim_eff = DimW'(1);
    else if (32'(dim_q) > MaxDim) dim_eff = DimW'(MaxDim);
    else dim_eff = DimW'(dim_q);
    n_eff = (32'(probe_q) < 32'(cnt_eff)) ? CntW'(probe_q) : cnt_eff;
  end

  function automatic logic signed [ValueW-1:0] sx(input logic [ValueW-1:0] v);
    logic [ValueBits-1:0] t;
    t = v[ValueBits-1:0];
    return ValueW'($signed(t));
  endfunction

  logic [2:0]      st_q, st_d;
  logic [CntW-1:0] s_q;       // slot counter
  logic [DimW-1:0] j_q;       // element counter
  logic            rv_q;      // read data valid this cycle
  logic [CW-1:0]   rs_q;      // slot of pending read
  logic            rlast_q;
  logic [RankW:0]  r_q;
  logic [MaxCentroids-1:0] used_q;
  logic            bv_q;
  logic [CW-1:0]   best_q;
  logic signed [ScoreW-1:0] bscore_q;
  logic            oval_q;

  logic in_acc, slot_ok, elem_ok, qend;
  assign in_stall_o = (st_q != StIdle);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign slot_ok = 32'(slot_i) < MaxCentroids;
  assign elem_ok = 32'(element_index_i) < MaxDim;
  assign qend    = action_i == ActQuery && 32'(element_index_i) == 32'(dim_eff) - 1;

  // memories
  logic          st_we, id_we, q_we, sc_we;
  logic [SW-1:0] st_wa, st_ra;
  logic [ValueW-1:0] st_rd, q_rd;
  logic [IdW-1:0] id_rd;
  logic [ScoreW-1:0] sc_rd, sc_wd;
  logic [CW-1:0] id_ra, sc_ra, sc_wa;
  logic [DW-1:0] q_ra;

  assign st_we = in_acc && action_i == ActCentroid && slot_ok && elem_ok;
  assign id_we = in_acc && action_i == ActCentroid && slot_ok;
  assign q_we  = in_acc && action_i == ActQuery && elem_ok;
  assign st_wa = SW'(32'(slot_i) * MaxDim + 32'(element_index_i));

  rcps_ram #(.Width(ValueW), .Depth(StoreD)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(value_i),
    .raddr_i(st_ra), .rdata_o(st_rd));
  rcps_ram #(.Width(IdW), .Depth(MaxCentroids)) u_ids (
    .clk_i, .we_i(id_we), .waddr_i(CW'(slot_i)), .wdata_i(centroid_id_i),
    .raddr_i(id_ra), .rdata_o(id_rd));
  rcps_ram #(.Width(ValueW), .Depth(MaxDim)) u_query (
    .clk_i, .we_i(q_we), .waddr_i(DW'(element_index_i)), .wdata_i(value_i),
    .raddr_i(q_ra), .rdata_o(q_rd));
  rcps_ram #(.Width(ScoreW), .Depth(MaxCentroids)) u_score (
    .clk_i, .we_i(sc_we), .waddr_i(sc_wa), .wdata_i(sc_wd),
    .raddr_i(sc_ra), .rdata_o(sc_rd));

  // score pass: slot-major, one element per cycle; each slot accumulates in acc_q
  logic signed [ScoreW-1:0] acc_q;
  logic signed [ValueW:0]   diff;
  logic signed [2*ValueW+1:0] prod_q;
  logic            pv_q, plast_q, pf_q;
  logic [CW-1:0]   ps_q;
  logic            first_q;   // read data in flight is element 0 of its slot

  assign st_ra = SW'(32'(s_q[CW-1:0]) * MaxDim + 32'(j_q[DW-1:0]));
  assign q_ra  = j_q[DW-1:0];
  assign diff  = (ValueW+1)'(sx(st_rd)) - (ValueW+1)'(sx(q_rd));

  logic signed [ScoreW-1:0] acc_base, acc_new;
  assign acc_base = pf_q ? '0 : acc_q;
  assign acc_new  = metric_q ? acc_base + ScoreW'(prod_q) : acc_base - ScoreW'(prod_q);
  assign sc_we = pv_q && plast_q;
  assign sc_wa = ps_q;
  assign sc_wd = acc_new;

  logic sel_hit;
  assign sel_hit = rv_q && !used_q[rs_q] &&
                   (!bv_q || $signed(sc_rd) > bscore_q);
  assign sc_ra = s_q[CW-1:0];
  assign id_ra = best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; s_q <= '0; j_q <= '0; rv_q <= 1'b0; pv_q <= 1'b0;
      r_q <= '0; used_q <= '0; bv_q <= 1'b0; oval_q <= 1'b0; first_q <= 1'b0;
      rs_q <= '0; rlast_q <= 1'b0; best_q <= '0; bscore_q <= '0;
      prod_q <= '0; plast_q <= 1'b0; ps_q <= '0; pf_q <= 1'b0; acc_q <= '0;
      score_o <= '0; rank_o <= '0; last_o <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StIdle: begin
          if (in_acc && qend) begin
            s_q <= '0; j_q <= '0;
          end
        end
        StScore: begin
          if (32'(s_q) < 32'(cnt_eff)) begin
            rv_q <= 1'b1; rs_q <= s_q[CW-1:0];
            rlast_q <= (32'(j_q) == 32'(dim_eff) - 1);
            first_q <= (j_q == '0);
            if (32'(j_q) == 32'(dim_eff) - 1) begin
              j_q <= '0; s_q <= s_q + CntW'(1);
            end else begin
              j_q <= j_q + DimW'(1);
            end
          end else begin
            rv_q <= 1'b0;
          end
          pv_q <= rv_q;
          if (rv_q) begin
            prod_q  <= metric_q ?
                       (2*ValueW+2)'(sx(st_rd)) * (2*ValueW+2)'(sx(q_rd)) : diff * diff;
            plast_q <= rlast_q; ps_q <= rs_q; pf_q <= first_q;
          end
          if (pv_q) acc_q <= acc_new;
          if (st_d == StSel) begin
            s_q <= '0; r_q <= '0; used_q <= '0; bv_q <= 1'b0;
          end
        end
        StSel: begin
          if (32'(s_q) < 32'(cnt_eff)) begin
            rv_q <= 1'b1; rs_q <= s_q[CW-1:0]; s_q <= s_q + CntW'(1);
          end else begin
            rv_q <= 1'b0;
          end
          if (sel_hit) begin
            bv_q <= 1'b1; best_q <= rs_q; bscore_q <= $signed(sc_rd);
          end
        end
        StMark: begin
          used_q[best_q] <= 1'b1;
          oval_q <= 1'b1;
          score_o <= bscore_q;
          rank_o <= r_q[RankW-1:0];
          last_o <= (32'(r_q) == 32'(n_eff) - 1);
        end
        StEmit: begin
          if (oval_q && !out_stall_i) begin
            oval_q <= 1'b0; r_q <= r_q + (RankW+1)'(1);
            s_q <= '0; bv_q <= 1'b0; rv_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (in_acc && qend) st_d = StScore;
      StScore: if (32'(s_q) >= 32'(cnt_eff) && !rv_q && !pv_q)
                 st_d = (n_eff == '0) ? StIdle : StSel;
      StSel:   if (32'(s_q) >= 32'(cnt_eff) && !rv_q) st_d = StMark;
      StMark:  st_d = StEmit;
      StEmit:  if (oval_q && !out_stall_i)
                 st_d = (32'(r_q) + 1 >= 32'(n_eff)) ? StIdle : StSel;
      default: st_d = StIdle;
    endcase
  end

  assign out_valid_o = oval_q;
  assign list_id_o   = id_rd;
endmodule
